// ----- design/ppmg_pkg.sv -----
// shared types and constants for the ppm frame generator
package ppmg_pkg;

   typedef enum logic [1:0] {
      FUNC_TICK   = 2'd0,
      FUNC_WIDTH  = 2'd1,
      FUNC_ENABLE = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      CSR_FRAME_LENGTH  = 2'd0,
      CSR_PULSE_LENGTH  = 2'd1,
      CSR_DEFAULT_WIDTH = 2'd2,
      CSR_UNUSED        = 2'd3
   } csr_index_type;

   localparam logic [15:0] FRAME_LENGTH_RESET  = 16'd22500;
   localparam logic [11:0] PULSE_LENGTH_RESET  = 12'd400;
   localparam logic [15:0] DEFAULT_WIDTH_RESET = 16'd1500;
   localparam logic [17:0] COUNT_MAX           = 18'h3FFFF;

   typedef struct packed {
      func_type    func;
      logic [2:0]  chan_index;
      logic [15:0] width_us;
      logic        enable_value;
   } req_type;

   typedef struct packed {
      logic       output_enabled;
      logic       frame_restart;
      logic [3:0] channel_now;
      logic       signal_level;
   } rsp_type;

endpackage

// ----- design/ppmg_core.sv -----
// frame timing state, interval reload and channel sequencing
module ppmg_core
   import ppmg_pkg::*;
#(
   parameter int NUM_CHANNELS = 8,
   parameter int TICKS_PER_US = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        step,
   input  req_type     req,
   output rsp_type     rsp
);

   localparam int CW = $clog2(NUM_CHANNELS + 1);
   localparam int IW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam logic signed [5:0] TICKS_S = 6'(TICKS_PER_US);

   logic [15:0]   frame_len_ff;
   logic [11:0]   pulse_len_ff;
   logic [15:0]   widths_ff [NUM_CHANNELS];
   logic [17:0]   countdown_ff, countdown_in;
   logic [CW-1:0] counter_ff, counter_in;
   logic [19:0]   elapsed_ff, elapsed_in;
   logic          next_level_ff, next_level_in;
   logic          line_level_ff, line_level_in;
   logic          enable_ff, enable_in;

   logic               expire;
   logic               hold;
   logic               at_sync;
   logic               restart;
   logic [15:0]        width_sel;
   logic signed [21:0] interval_us;
   logic signed [27:0] interval_ticks;
   logic [17:0]        reload;
   logic [CW+3:0]      counter_ext;
   logic               width_write;

   // configuration registers, default width only matters at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_len_ff <= FRAME_LENGTH_RESET;
         pulse_len_ff <= PULSE_LENGTH_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_LENGTH:  frame_len_ff <= csr_wdata;
            CSR_PULSE_LENGTH:  pulse_len_ff <= csr_wdata[11:0];
            CSR_DEFAULT_WIDTH: ;
            default: ;
         endcase
      end
   end

   assign width_write = step && (req.func == FUNC_WIDTH) &&
                        ({2'b00, req.chan_index} < 5'(NUM_CHANNELS));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            widths_ff[i] <= DEFAULT_WIDTH_RESET;
         end
      end else if (width_write) begin
         widths_ff[IW'(req.chan_index)] <= req.width_us;
      end
   end

   assign expire    = step && (req.func == FUNC_TICK) && (countdown_ff <= 18'd1);
   assign hold      = !enable_ff && (counter_ff == '0);
   assign at_sync   = (counter_ff == CW'(NUM_CHANNELS));
   assign width_sel = widths_ff[counter_ff[IW-1:0]];

   always_comb begin
      if (hold) begin
         interval_us = 22'({6'b0, frame_len_ff});
      end else if (next_level_ff) begin
         interval_us = 22'({10'b0, pulse_len_ff});
      end else if (at_sync) begin
         interval_us = 22'({6'b0, frame_len_ff}) - 22'({10'b0, pulse_len_ff})
                       - 22'({2'b0, elapsed_ff});
      end else begin
         interval_us = 22'({6'b0, width_sel}) - 22'({10'b0, pulse_len_ff});
      end
   end

   assign interval_ticks = 28'(interval_us) * 28'(TICKS_S);

   always_comb begin
      if (interval_ticks < 28'sd1) begin
         reload = 18'd1;
      end else if (interval_ticks > 28'(COUNT_MAX)) begin
         reload = COUNT_MAX;
      end else begin
         reload = interval_ticks[17:0];
      end
   end

   always_comb begin
      countdown_in  = countdown_ff;
      counter_in    = counter_ff;
      elapsed_in    = elapsed_ff;
      next_level_in = next_level_ff;
      line_level_in = line_level_ff;
      enable_in     = enable_ff;
      restart       = 1'b0;
      if (expire) begin
         countdown_in = reload;
         if (!hold) begin
            line_level_in = next_level_ff;
            next_level_in = !next_level_ff;
            if (!next_level_ff) begin
               if (at_sync) begin
                  counter_in = '0;
                  elapsed_in = '0;
                  restart    = 1'b1;
               end else begin
                  counter_in = counter_ff + CW'(1);
                  elapsed_in = elapsed_ff + 20'(width_sel);
               end
            end
         end
      end else if (step && (req.func == FUNC_TICK)) begin
         countdown_in = countdown_ff - 18'd1;
      end else if (step && (req.func == FUNC_ENABLE)) begin
         enable_in = req.enable_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         countdown_ff  <= 18'd1;
         counter_ff    <= '0;
         elapsed_ff    <= '0;
         next_level_ff <= 1'b1;
         line_level_ff <= 1'b0;
         enable_ff     <= 1'b0;
      end else begin
         countdown_ff  <= countdown_in;
         counter_ff    <= counter_in;
         elapsed_ff    <= elapsed_in;
         next_level_ff <= next_level_in;
         line_level_ff <= line_level_in;
         enable_ff     <= enable_in;
      end
   end

   assign counter_ext = (CW + 4)'(counter_in);

   always_comb begin
      rsp.signal_level   = line_level_in;
      rsp.channel_now    = counter_ext[3:0];
      rsp.frame_restart  = restart;
      rsp.output_enabled = enable_in;
   end

endmodule

// ----- design/ppm_frame_generator.sv -----
// top level of the ppm frame generator: request register, core, response register
// a request passes from the request register through the core into the response register
// throughput: one request per cycle while the response is not stalled, set by the state update in the core
// a stalled response blocks requests once the request register also holds one
// reset is synchronous and active high; it clears both handshake stages and all timing state
// channel widths come out of reset at the default width, registers at their reset values
module ppm_frame_generator
   import ppmg_pkg::*;
#(
   parameter int NUM_CHANNELS = 8,
   parameter int TICKS_PER_US = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // chan_index, width_us, enable_value, zero pad
   input  logic [1:0]  req_tuser,   // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // signal_level, channel_now, frame_restart, output_enabled, pad
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic    in_valid_ff, in_valid_in;
   req_type in_req_ff, in_req_in;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_rsp_ff;
   rsp_type core_rsp;
   logic    proc_fire;

   assign proc_fire  = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || proc_fire;

   always_comb begin
      in_req_in.func         = func_type'(req_tuser);
      in_req_in.chan_index   = req_tdata[2:0];
      in_req_in.width_us     = req_tdata[18:3];
      in_req_in.enable_value = req_tdata[19];
      in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !proc_fire);
      out_valid_in = proc_fire || (out_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_req_ff <= in_req_in;
      end
      if (proc_fire) begin
         out_rsp_ff <= core_rsp;
      end
   end

   ppmg_core #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .TICKS_PER_US (TICKS_PER_US)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .step      (proc_fire),
      .req       (in_req_ff),
      .rsp       (core_rsp)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_rsp_ff};

endmodule

// ----- design/ppmg_checker.sv -----
// port-level checks for the ppm frame generator, bound to the top level
module ppmg_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // frame restart lands at channel zero with the line low
   a_restart_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[5] |-> (rsp_tdata[4:1] == 4'd0) && !rsp_tdata[0])
      else $error("frame restart outside channel zero or with line high");

   // an empty output stage never blocks requests
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty output stage");

   // reset empties the output stage
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

bind ppm_frame_generator ppmg_checker u_ppmg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
